>>> hdl/pgrm_pkg.sv
// ----------------------------------------------------------------------------
// pgrm_pkg
// Shared sizes, register indexes, controller states and command structs for
// the per-group running mean block.
// ----------------------------------------------------------------------------
package pgrm_pkg;

  localparam int GROUPS      = 16;
  localparam int MAX_SAMPLES = 1024;

  localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int DEPTH  = GROUPS * MAX_SAMPLES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int SPT_W   = 11;
  localparam int IDX_W   = 10;
  localparam int X_W     = 16;
  localparam int MEAN_W  = 32;
  localparam int CNT_W   = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [SPT_W-1:0] SPT_RESET = 11'd1024;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_TRACE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_GROUPS        = 1'd1;

  localparam int DIV_STEPS = MEAN_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic ACTION_ACCUMULATE = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_FETCH,
    ST_MUL,
    ST_SUM,
    ST_ABS,
    ST_DIV,
    ST_WRITE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic ram_read;
    logic fetch;
    logic mul;
    logic sum;
    logic div_init;
    logic div_step;
    logic write_back;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic update;
    logic out_ready;
  } ctrl_status_t;

endpackage

>>> hdl/pgrm_ram.sv
// ----------------------------------------------------------------------------
// pgrm_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pgrm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/pgrm_ctrl.sv
// ----------------------------------------------------------------------------
// pgrm_ctrl
// Sequencer for one item at a time: read and fetch, then for an update item
// multiply, add, divide and write back, and hand the result to the output register.
// ----------------------------------------------------------------------------
module pgrm_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  pgrm_pkg::ctrl_status_t  status,
  output pgrm_pkg::ctrl_cmd_t     cmd
);

  pgrm_pkg::state_t state;
  pgrm_pkg::state_t state_next;
  logic [pgrm_pkg::DIV_CNT_W-1:0] step;
  logic                           step_last;

  assign step_last = (step == pgrm_pkg::DIV_CNT_W'(pgrm_pkg::DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pgrm_pkg::ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == pgrm_pkg::ST_DIV) begin
        step <= step + pgrm_pkg::DIV_CNT_W'(1);
      end else begin
        step <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pgrm_pkg::ST_IDLE:   if (in_valid) state_next = pgrm_pkg::ST_READ;
      pgrm_pkg::ST_READ:   state_next = pgrm_pkg::ST_FETCH;
      pgrm_pkg::ST_FETCH: begin
        state_next = status.update ? pgrm_pkg::ST_MUL : pgrm_pkg::ST_FINISH;
      end
      pgrm_pkg::ST_MUL:    state_next = pgrm_pkg::ST_SUM;
      pgrm_pkg::ST_SUM:    state_next = pgrm_pkg::ST_ABS;
      pgrm_pkg::ST_ABS:    state_next = pgrm_pkg::ST_DIV;
      pgrm_pkg::ST_DIV:    if (step_last) state_next = pgrm_pkg::ST_WRITE;
      pgrm_pkg::ST_WRITE:  state_next = pgrm_pkg::ST_FINISH;
      pgrm_pkg::ST_FINISH: if (status.out_ready) state_next = pgrm_pkg::ST_IDLE;
      default:             state_next = pgrm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      pgrm_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      pgrm_pkg::ST_READ:   cmd.ram_read   = 1'b1;
      pgrm_pkg::ST_FETCH:  cmd.fetch      = 1'b1;
      pgrm_pkg::ST_MUL:    cmd.mul        = 1'b1;
      pgrm_pkg::ST_SUM:    cmd.sum        = 1'b1;
      pgrm_pkg::ST_ABS:    cmd.div_init   = 1'b1;
      pgrm_pkg::ST_DIV:    cmd.div_step   = 1'b1;
      pgrm_pkg::ST_WRITE:  cmd.write_back = 1'b1;
      pgrm_pkg::ST_FINISH: cmd.out_load   = status.out_ready;
      default:             cmd            = '0;
    endcase
  end

endmodule

>>> hdl/pgrm_datapath.sv
// ----------------------------------------------------------------------------
// pgrm_datapath
// Configuration, group counts, mean store, multiplier, restoring divider and
// output register.
// ----------------------------------------------------------------------------
module pgrm_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [pgrm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pgrm_pkg::SPT_W-1:0]           cfg_data,
  input  logic                                 action,
  input  logic [3:0]                           group,
  input  logic [pgrm_pkg::IDX_W-1:0]           sample_index,
  input  logic signed [pgrm_pkg::X_W-1:0]      sample_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [pgrm_pkg::MEAN_W-1:0]   mean_value,
  output logic [pgrm_pkg::CNT_W-1:0]           trace_count,
  input  pgrm_pkg::ctrl_cmd_t                  cmd,
  output pgrm_pkg::ctrl_status_t               status
);

  logic [pgrm_pkg::SPT_W-1:0] samples_per_trace;
  logic                       use_groups;

  logic [pgrm_pkg::SPT_W-1:0]  len;
  logic [pgrm_pkg::GRP_W-1:0]  grp_sel;
  logic [pgrm_pkg::ADDR_W-1:0] addr_sel;
  logic                        upd_sel;
  logic                        last_sel;

  logic [pgrm_pkg::GRP_W-1:0]        grp_r;
  logic [pgrm_pkg::ADDR_W-1:0]       addr_r;
  logic signed [pgrm_pkg::X_W-1:0]   x_r;
  logic                              upd_r;
  logic                              last_r;

  logic [pgrm_pkg::CNT_W-1:0] counts [pgrm_pkg::GROUPS];
  logic [pgrm_pkg::CNT_W-1:0] cnt_r;
  logic [pgrm_pkg::CNT_W-1:0] cnt_next;

  logic signed [pgrm_pkg::MEAN_W-1:0] mean_r;
  logic [pgrm_pkg::MEAN_W-1:0]        ram_rdata;

  logic signed [64:0] prod_full;
  logic signed [63:0] prod;
  logic signed [63:0] acc;
  logic [63:0]        x_ext;
  logic [63:0]        mag;

  logic        neg;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [32:0] divisor;
  logic [32:0] trial;
  logic        trial_ge;
  logic signed [pgrm_pkg::MEAN_W-1:0] q_signed;

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_trace <= pgrm_pkg::SPT_RESET;
      use_groups        <= 1'b1;
    end else if (cfg_write) begin
      if (cfg_index == pgrm_pkg::CFG_SAMPLES_PER_TRACE) begin
        samples_per_trace <= cfg_data;
      end else if (cfg_index == pgrm_pkg::CFG_USE_GROUPS) begin
        use_groups <= cfg_data[0];
      end
    end
  end

  always_comb begin
    if (samples_per_trace == '0) begin
      len = pgrm_pkg::SPT_W'(1);
    end else if (32'(samples_per_trace) > pgrm_pkg::MAX_SAMPLES) begin
      len = pgrm_pkg::SPT_W'(pgrm_pkg::MAX_SAMPLES);
    end else begin
      len = samples_per_trace;
    end
    grp_sel  = pgrm_pkg::GRP_W'((use_groups ? 32'(group) : 32'd0) % pgrm_pkg::GROUPS);
    addr_sel = pgrm_pkg::ADDR_W'(32'(grp_sel) * pgrm_pkg::MAX_SAMPLES
                                 + 32'(sample_index) % pgrm_pkg::MAX_SAMPLES);
    upd_sel  = (action == pgrm_pkg::ACTION_ACCUMULATE)
               && (pgrm_pkg::SPT_W'(sample_index) < len);
    last_sel = (pgrm_pkg::SPT_W'(sample_index) == len - pgrm_pkg::SPT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      grp_r  <= grp_sel;
      addr_r <= addr_sel;
      x_r    <= sample_value;
      upd_r  <= upd_sel;
      last_r <= last_sel;
    end
  end

  pgrm_ram #(
    .WIDTH (pgrm_pkg::MEAN_W),
    .DEPTH (pgrm_pkg::DEPTH)
  ) u_mean_store (
    .clk   (clk),
    .we    (cmd.write_back),
    .waddr (addr_r),
    .wdata (q_signed),
    .re    (cmd.ram_read),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  assign prod_full = mean_r * $signed({1'b0, cnt_r});
  assign x_ext     = {{32{x_r[pgrm_pkg::X_W-1]}}, x_r, 16'd0};
  assign mag       = acc[63] ? 64'(-acc) : 64'(acc);
  assign trial     = {rem, quo[31]};
  assign trial_ge  = (trial >= divisor);
  assign q_signed  = neg ? -$signed(quo) : $signed(quo);
  assign cnt_next  = (last_r && cnt_r != '1) ? cnt_r + pgrm_pkg::CNT_W'(1) : cnt_r;

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      mean_r <= (counts[grp_r] == '0) ? '0 : $signed(ram_rdata);
      cnt_r  <= counts[grp_r];
    end
    if (cmd.mul) begin
      prod <= prod_full[63:0];
    end
    if (cmd.sum) begin
      acc <= prod + $signed(x_ext);
    end
    if (cmd.div_init) begin
      neg     <= acc[63];
      rem     <= mag[63:32];
      quo     <= mag[31:0];
      divisor <= {1'b0, cnt_r} + 33'd1;
    end
    if (cmd.div_step) begin
      rem <= trial_ge ? 32'(trial - divisor) : trial[31:0];
      quo <= {quo[30:0], trial_ge};
    end
    if (cmd.write_back) begin
      mean_r <= q_signed;
      cnt_r  <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < pgrm_pkg::GROUPS; g++) begin
        counts[g] <= '0;
      end
    end else if (cmd.write_back) begin
      counts[grp_r] <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      mean_value  <= (cnt_r == '0) ? '0 : mean_r;
      trace_count <= cnt_r;
    end
  end

  assign status.update    = upd_r;
  assign status.out_ready = !out_valid || !out_stall;

endmodule

>>> hdl/per_group_running_mean.sv
// ----------------------------------------------------------------------------
// per_group_running_mean
// Running mean of each sample point per group, with trace counts.
// ----------------------------------------------------------------------------
// Read beat: read and fetch, then finish loads the output register once free.
// Accumulate beat: read, fetch, multiply, add, then the 32-step restoring
// divider by count plus one, write back and finish; input stalls till idle.
// Reset clears the group counts and output valid and resets the configuration;
// the mean store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module per_group_running_mean (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [pgrm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pgrm_pkg::SPT_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               action,
  input  logic [3:0]                         group,
  input  logic [pgrm_pkg::IDX_W-1:0]         sample_index,
  input  logic signed [pgrm_pkg::X_W-1:0]    sample_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [pgrm_pkg::MEAN_W-1:0] mean_value,
  output logic [pgrm_pkg::CNT_W-1:0]         trace_count
);

  pgrm_pkg::ctrl_cmd_t    cmd;
  pgrm_pkg::ctrl_status_t status;

  pgrm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  pgrm_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .action       (action),
    .group        (group),
    .sample_index (sample_index),
    .sample_value (sample_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .mean_value   (mean_value),
    .trace_count  (trace_count),
    .cmd          (cmd),
    .status       (status)
  );

endmodule
